/* rtl/core/sst_pkg.sv */
// sst_pkg: shared types and constants for the sorted set table.
// No dependencies; used by sst_cell and sorted_set_table_unit.
package sst_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} shift_cmd_t;

	// Signed order on two's-complement patterns.
	function automatic logic less_than(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b);
		less_than = $signed(a) < $signed(b);
	endfunction

endpackage

/* rtl/core/sst_cell.sv */
// sst_cell: one entry of the sorted chain with its compare and shift logic.
// Depends on sst_pkg.
module sst_cell
	import sst_pkg::*;
#(
	parameter int IDX     = 0,
	parameter int COUNT_W = 5
) (
	input  logic               clk,
	input  logic [COUNT_W-1:0] count_q,
	input  shift_cmd_t         cmd,
	input  logic [VALUE_W-1:0] key,
	input  logic               prev_lt,
	input  logic [VALUE_W-1:0] prev_entry,
	input  logic               has_next,
	input  logic [VALUE_W-1:0] next_entry,
	output logic [VALUE_W-1:0] entry_q,
	output logic               valid,
	output logic               lt,
	output logic               eq
);

	logic [VALUE_W-1:0] entry_d;

	assign valid = count_q > COUNT_W'(IDX);
	assign lt    = valid & less_than(entry_q, key);
	assign eq    = valid & (entry_q == key);

	always_comb begin
		entry_d = entry_q;
		if (cmd.ins && !lt) begin
			// open the slot at the insertion point, shift the rest up
			entry_d = (IDX == 0 || prev_lt) ? key : prev_entry;
		end else if (cmd.rem && !lt && has_next) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

/* rtl/core/sorted_set_table_unit.sv */
// Sorted set table: a chain of CAPACITY cells kept in ascending order.
// The result word appears with done in the cycle after start is taken.
// Throughput: one word per cycle; busy stays low, and each cell's compare and shift are combinational.
// Reset: arst_n empties the set; entry contents are undefined until written.
// Results cannot be stalled: done is a single-cycle strobe.
module sorted_set_table_unit
	import sst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      done,
	output logic                      found,
	output logic                      dropped_full,
	output logic [COUNT_OUT_W-1:0]    count,
	output logic signed [VALUE_W-1:0] smallest,
	output logic signed [VALUE_W-1:0] largest
);

	localparam int COUNT_W = $clog2(CAPACITY + 1);

	logic [COUNT_W-1:0] count_q;
	logic               done_q;
	logic               found_q;
	logic               dropped_q;

	logic [VALUE_W-1:0] entry_q [CAPACITY];
	logic [CAPACITY-1:0] valid_v, lt_v, eq_v;
	logic [VALUE_W-1:0] key;
	shift_cmd_t         cmd;
	mode_t              mode_in;
	logic               accept;
	logic               hit;
	logic               full;
	logic [VALUE_W-1:0] top_entry;

	assign key     = value;
	assign mode_in = mode_t'(mode);
	assign accept  = start & ~busy;
	assign busy    = 1'b0;
	assign hit     = |eq_v;
	assign full    = count_q == COUNT_W'(CAPACITY);

	always_comb begin
		cmd.ins = accept && mode_in == MODE_INSERT && !hit && !full;
		cmd.rem = accept && mode_in == MODE_REMOVE && hit;
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			sst_cell #(
				.IDX     (gi),
				.COUNT_W (COUNT_W)
			) u_cell (
				.clk        (clk),
				.count_q    (count_q),
				.cmd        (cmd),
				.key        (key),
				.prev_lt    ((gi == 0) ? 1'b0 : lt_v[(gi == 0) ? 0 : gi-1]),
				.prev_entry (entry_q[(gi == 0) ? 0 : gi-1]),
				.has_next   ((gi == CAPACITY-1) ? 1'b0 : 1'b1),
				.next_entry (entry_q[(gi == CAPACITY-1) ? gi : gi+1]),
				.entry_q    (entry_q[gi]),
				.valid      (valid_v[gi]),
				.lt         (lt_v[gi]),
				.eq         (eq_v[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				found_q   <= hit;
				dropped_q <= mode_in == MODE_INSERT && !hit && full;
				if (mode_in == MODE_CLEAR) begin
					count_q <= '0;
				end else if (cmd.ins) begin
					count_q <= count_q + COUNT_W'(1);
				end else if (cmd.rem) begin
					count_q <= count_q - COUNT_W'(1);
				end
			end
		end
	end

	// pick the last valid cell
	always_comb begin
		top_entry = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (valid_v[i] && (i == CAPACITY-1 || !valid_v[(i == CAPACITY-1) ? i : i+1])) begin
				top_entry = entry_q[i];
			end
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign dropped_full = dropped_q;
	assign count        = COUNT_OUT_W'(count_q);
	assign smallest     = valid_v[0] ? entry_q[0] : '0;
	assign largest      = valid_v[0] ? top_entry : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && dropped_q |-> !found_q && count_q == COUNT_W'(CAPACITY))
		else $error("drop reported while not full or value present");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_in == MODE_CLEAR |=> count_q == '0)
		else $error("clear did not empty the set");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.rem))
		else $error("insert and remove shift together");

endmodule
